>>> rtl/core/plhc_pkg.sv
// shared types and constants for the pinned lru handle cache
package plhc_pkg;

    localparam int SLOT_COUNT     = 32;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int MAX_KEY_LENGTH = 64 * 1024;
    localparam int TAG_WIDTH      = 64;
    localparam int STAMP_W        = 64;
    localparam int PIN_W          = 16;
    localparam logic [PIN_W-1:0] PIN_MAX = '1;
    localparam logic [14:0] MAX_STATES_RESET = 15'd10000;

    // commands
    localparam logic [1:0] CMD_LOOKUP  = 2'd0;
    localparam logic [1:0] CMD_FILL    = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // status codes
    localparam logic [3:0] ST_HIT         = 4'd0;
    localparam logic [3:0] ST_MISS        = 4'd1;
    localparam logic [3:0] ST_STORED      = 4'd2;
    localparam logic [3:0] ST_UNCACHED    = 4'd3;
    localparam logic [3:0] ST_BAD_LEN     = 4'd4;
    localparam logic [3:0] ST_COMP_FAIL   = 4'd5;
    localparam logic [3:0] ST_BAD_COUNT   = 4'd6;
    localparam logic [3:0] ST_TOO_MANY    = 4'd7;
    localparam logic [3:0] ST_RELEASED    = 4'd8;
    localparam logic [3:0] ST_REL_MISSING = 4'd9;
    localparam logic [3:0] ST_REL_NULL    = 4'd10;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key_tag;
        logic [16:0] key_length;
        logic        pin_request;
        logic [31:0] handle_in;
        logic signed [15:0] state_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] handle_out;
        logic        evicted_valid;
        logic [31:0] evicted_handle;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat, clear scan
        logic scan;      // examine slot r_idx
        logic commit;    // apply update and build result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // current slot is the last one, or the request is rejected
        logic found;      // early stop for lookup or release match, or empty slot on fill
    } t_dp_stat;

endpackage

>>> rtl/core/plhc_ctrl.sv
// controller sequencing load, slot scan, commit and result handoff
module plhc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd_none,
    input  plhc_pkg::t_dp_stat i_stat,
    output plhc_pkg::t_dp_cmd  o_cmd,
    output logic              o_valid,
    input  logic              i_stall
);
    import plhc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] r_state, n_state;
    logic       take;

    assign o_stall = (r_state != S_IDLE);
    assign take    = i_valid && (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (take && !i_cmd_none) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last || i_stat.found) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/plhc_dp.sv
// slot store, sequential match and victim scan, update and result register
module plhc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plhc_pkg::t_in_item i_item,
    input  logic               i_cfg_valid,
    input  logic [14:0]        i_cfg_data,
    input  plhc_pkg::t_dp_cmd  i_cmd,
    output plhc_pkg::t_dp_stat o_stat,
    output plhc_pkg::t_out_item o_item
);
    import plhc_pkg::*;

    // slot arrays, read at the scan index and at the target slot
    logic [SLOT_COUNT-1:0] r_valid;
    logic [TAG_WIDTH-1:0]  r_tag    [SLOT_COUNT];
    logic [16:0]           r_len    [SLOT_COUNT];
    logic [31:0]           r_handle [SLOT_COUNT];
    logic [STAMP_W-1:0]    r_stamp  [SLOT_COUNT];
    logic [PIN_W-1:0]      r_pins   [SLOT_COUNT];
    logic [STAMP_W-1:0]    r_clock;
    logic [14:0]           r_max_states;

    t_in_item              r_req;
    logic [SLOT_W-1:0]     r_idx;
    logic                  r_hit;       // match found or empty slot found
    logic                  r_tgt_ok;
    logic [SLOT_W-1:0]     r_tgt;
    logic [STAMP_W-1:0]    r_tgt_stamp;
    t_out_item             r_out;

    logic sel_valid, match_key, match_hnd, pre_err, cand;
    logic [STAMP_W-1:0] stamp_next;

    assign sel_valid = r_valid[r_idx];
    assign match_key = sel_valid && r_tag[r_idx] == r_req.key_tag[TAG_WIDTH-1:0]
                       && r_len[r_idx] == r_req.key_length;
    assign match_hnd = sel_valid && r_handle[r_idx] == r_req.handle_in;
    assign stamp_next = r_clock + 1'b1;

    // request checks for every command, decided before the scan
    always_comb begin
        pre_err = 1'b0;
        case (r_req.command)
            CMD_LOOKUP:  pre_err = r_req.key_length > 17'(MAX_KEY_LENGTH);
            CMD_FILL:    pre_err = r_req.key_length > 17'(MAX_KEY_LENGTH)
                                   || r_req.handle_in == '0 || r_req.state_count < 0
                                   || r_req.state_count[14:0] > r_max_states;
            CMD_RELEASE: pre_err = r_req.handle_in == '0;
            default:     pre_err = 1'b1;
        endcase
    end

    // unpinned slot that beats the current victim
    assign cand = sel_valid && r_pins[r_idx] == '0
                  && (!r_tgt_ok || r_stamp[r_idx] < r_tgt_stamp);

    assign o_stat.scan_last = (r_idx == SLOT_W'(SLOT_COUNT - 1)) || pre_err;
    always_comb begin
        case (r_req.command)
            CMD_LOOKUP:  o_stat.found = match_key;
            CMD_FILL:    o_stat.found = !sel_valid;
            CMD_RELEASE: o_stat.found = match_hnd;
            default:     o_stat.found = 1'b0;
        endcase
    end

    assign o_item = r_out;

    // request capture and scan state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_item;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_tgt_ok <= 1'b0;
        end else if (i_cmd.scan) begin
            if (o_stat.found && !pre_err) begin
                r_hit <= 1'b1;
                r_tgt <= r_idx;
            end else if (!pre_err && r_req.command == CMD_FILL && cand) begin
                r_tgt_ok    <= 1'b1;
                r_tgt       <= r_idx;
                r_tgt_stamp <= r_stamp[r_idx];
            end
            if (!(o_stat.found || o_stat.scan_last)) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // slot updates, config and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_clock      <= '0;
            r_max_states <= MAX_STATES_RESET;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_stamp[i] <= '0;
                r_pins[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_max_states <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_out <= '0;
                case (r_req.command)
                    CMD_LOOKUP: begin
                        if (pre_err) begin
                            r_out.status <= ST_BAD_LEN;
                        end else if (r_hit) begin
                            r_out.status     <= ST_HIT;
                            r_out.handle_out <= r_handle[r_tgt];
                            r_clock          <= stamp_next;
                            r_stamp[r_tgt]   <= stamp_next;
                            if (r_req.pin_request && r_pins[r_tgt] != PIN_MAX) begin
                                r_pins[r_tgt] <= r_pins[r_tgt] + 1'b1;
                            end
                        end else begin
                            r_out.status <= ST_MISS;
                        end
                    end
                    CMD_FILL: begin
                        if (r_req.key_length > 17'(MAX_KEY_LENGTH)) begin
                            r_out.status         <= ST_BAD_LEN;
                            r_out.evicted_handle <= r_req.handle_in;
                        end else if (r_req.handle_in == '0) begin
                            r_out.status <= ST_COMP_FAIL;
                        end else if (r_req.state_count < 0) begin
                            r_out.status         <= ST_BAD_COUNT;
                            r_out.evicted_handle <= r_req.handle_in;
                        end else if (pre_err) begin
                            r_out.status         <= ST_TOO_MANY;
                            r_out.evicted_handle <= r_req.handle_in;
                        end else if (!r_hit && !r_tgt_ok) begin
                            r_out.status     <= ST_UNCACHED;
                            r_out.handle_out <= r_req.handle_in;
                        end else begin
                            r_out.status     <= ST_STORED;
                            r_out.handle_out <= r_req.handle_in;
                            if (!r_hit) begin
                                r_out.evicted_valid  <= 1'b1;
                                r_out.evicted_handle <= r_handle[r_tgt];
                            end
                            r_valid[r_tgt]  <= 1'b1;
                            r_tag[r_tgt]    <= r_req.key_tag[TAG_WIDTH-1:0];
                            r_len[r_tgt]    <= r_req.key_length;
                            r_handle[r_tgt] <= r_req.handle_in;
                            r_stamp[r_tgt]  <= stamp_next;
                            r_clock         <= stamp_next;
                            r_pins[r_tgt]   <= PIN_W'(r_req.pin_request);
                        end
                    end
                    CMD_RELEASE: begin
                        if (pre_err) begin
                            r_out.status <= ST_REL_NULL;
                        end else if (r_hit) begin
                            r_out.status <= ST_RELEASED;
                            if (r_pins[r_tgt] != '0) begin
                                r_pins[r_tgt] <= r_pins[r_tgt] - 1'b1;
                            end
                        end else begin
                            r_out.status         <= ST_REL_MISSING;
                            r_out.evicted_handle <= r_req.handle_in;
                        end
                    end
                    default: r_out.status <= ST_MISS;
                endcase
            end
        end
    end

endmodule

>>> rtl/core/pinned_lru_handle_cache_unit.sv
// top level of the pinned lru handle cache
// One command is handled at a time. After the beat is taken, the slot scan examines one slot
// per cycle (up to 32, stopping early at a lookup or release match or at an empty slot on
// fill; rejected commands end the scan at its first slot), then a commit state updates the
// slot and registers the result before the result is handed off.
// Command code 3 is dropped with no result. The threshold register is written through the
// configuration channel, which is always ready.
module pinned_lru_handle_cache_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  plhc_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output plhc_pkg::t_out_item  o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [14:0]          i_cfg_data
);
    import plhc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    // control sequencer
    plhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd_none (i_item.command == CMD_NONE),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall)
    );

    // slot store and result path
    plhc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_item      (o_item)
    );

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the pinned lru handle cache unit
module tb_top;
    import plhc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_item i_item = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_item o_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [14:0] i_cfg_data = '0;

    pinned_lru_handle_cache_unit uut (.*);

    always #1 i_clk = ~i_clk;

    // predicted cache contents
    logic [14:0] max_states;
    logic        c_valid [SLOT_COUNT];
    logic [63:0] c_tag [SLOT_COUNT];
    logic [16:0] c_len [SLOT_COUNT];
    logic [31:0] c_handle [SLOT_COUNT];
    logic [63:0] c_stamp [SLOT_COUNT];
    logic [15:0] c_pins [SLOT_COUNT];
    logic [63:0] use_clock;

    t_in_item  pending_cmds[$];
    t_out_item expected_results[$];
    int  errors = 0;
    int  hold_cycles = 0;
    bit  long_hold_req = 1'b0;
    int  rx_wait = 0;

    task automatic clear_cache();
        max_states = MAX_STATES_RESET;
        use_clock = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            c_valid[i] = 1'b0; c_stamp[i] = '0; c_pins[i] = '0;
            c_tag[i] = '0; c_len[i] = '0; c_handle[i] = '0;
        end
    endtask

    // compute one result and update the predicted cache
    function automatic bit cache_predict(input t_in_item it, output t_out_item r);
        int tgt;
        tgt = -1;
        r = '0;
        if (it.command == CMD_NONE) return 1'b0;
        if (it.command == CMD_LOOKUP) begin
            if (it.key_length > MAX_KEY_LENGTH) r.status = ST_BAD_LEN;
            else begin
                r.status = ST_MISS;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (c_valid[i] && c_tag[i] == it.key_tag && c_len[i] == it.key_length) begin
                        use_clock = use_clock + 1;
                        c_stamp[i] = use_clock;
                        if (it.pin_request && c_pins[i] != PIN_MAX) c_pins[i]++;
                        r.status = ST_HIT;
                        r.handle_out = c_handle[i];
                        break;
                    end
                end
            end
        end else if (it.command == CMD_FILL) begin
            if (it.key_length > MAX_KEY_LENGTH) begin
                r.status = ST_BAD_LEN; r.evicted_handle = it.handle_in;
            end else if (it.handle_in == 0) begin
                r.status = ST_COMP_FAIL;
            end else if (it.state_count < 0) begin
                r.status = ST_BAD_COUNT; r.evicted_handle = it.handle_in;
            end else if (it.state_count > $signed({1'b0, max_states})) begin
                r.status = ST_TOO_MANY; r.evicted_handle = it.handle_in;
            end else begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!c_valid[i]) begin
                        tgt = i;
                        break;
                    end
                    if (c_pins[i] != 0) continue;
                    if (tgt < 0 || c_stamp[i] < c_stamp[tgt]) tgt = i;
                end
                r.handle_out = it.handle_in;
                if (tgt < 0) r.status = ST_UNCACHED;
                else begin
                    if (c_valid[tgt]) begin
                        r.evicted_valid = 1'b1;
                        r.evicted_handle = c_handle[tgt];
                    end
                    c_valid[tgt] = 1'b1;
                    c_tag[tgt] = it.key_tag;
                    c_len[tgt] = it.key_length;
                    c_handle[tgt] = it.handle_in;
                    use_clock = use_clock + 1;
                    c_stamp[tgt] = use_clock;
                    c_pins[tgt] = it.pin_request ? 16'd1 : 16'd0;
                    r.status = ST_STORED;
                end
            end
        end else begin
            if (it.handle_in == 0) r.status = ST_REL_NULL;
            else begin
                r.status = ST_REL_MISSING;
                r.evicted_handle = it.handle_in;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (c_valid[i] && c_handle[i] == it.handle_in) begin
                        if (c_pins[i] != 0) c_pins[i]--;
                        r.status = ST_RELEASED;
                        r.evicted_handle = '0;
                        break;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    // driver: one beat at a time from the pending queue, idle gap drawn per item
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_out_item r;
        int gap;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (cache_predict(i_item, r)) expected_results.push_back(r);
                void'(pending_cmds.pop_front());
                gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 19));
                if (pending_cmds.size() > 0 && gap == 0) begin
                    i_item <= pending_cmds[0];
                end else begin
                    i_valid <= 1'b0;
                    send_gap <= (gap > 0) ? gap - 1 : 0;
                end
            end else if (!i_valid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (pending_cmds.size() > 0) begin
                    i_valid <= 1'b1;
                    i_item <= pending_cmds[0];
                end
            end
        end
    end

    // receiver stall and result checking, wait drawn per result beat
    always @(posedge i_clk) begin
        t_out_item exp_r;
        int w;
        if (i_rst_n) begin
            w = rx_wait;
            if (o_valid && !i_stall) begin
                w = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 19));
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat status=%0d", o_item.status);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_item.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, o_item.status); errors++;
                    end
                    if (o_item.handle_out !== exp_r.handle_out) begin
                        $error("handle_out exp %h got %h", exp_r.handle_out, o_item.handle_out);
                        errors++;
                    end
                    if (o_item.evicted_valid !== exp_r.evicted_valid) begin
                        $error("evicted_valid exp %0d got %0d", exp_r.evicted_valid,
                            o_item.evicted_valid); errors++;
                    end
                    if (o_item.evicted_handle !== exp_r.evicted_handle) begin
                        $error("evicted_handle exp %h got %h", exp_r.evicted_handle,
                            o_item.evicted_handle); errors++;
                    end
                end
            end else if (w > 0) begin
                w = w - 1;
            end
            rx_wait <= w;
            if (long_hold_req) begin
                hold_cycles <= 400;
                long_hold_req <= 1'b0;
                i_stall <= 1'b1;
            end else if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (w > 0);
            end
        end
    end

    function automatic t_in_item make_cmd(logic [1:0] c, logic [63:0] t, logic [16:0] l,
                                          logic p, logic [31:0] h, logic [15:0] s);
        t_in_item it;
        it.command = c; it.key_tag = t; it.key_length = l;
        it.pin_request = p; it.handle_in = h; it.state_count = s;
        return it;
    endfunction

    task automatic drain();
        wait (pending_cmds.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [14:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        max_states = v;
    endtask

    // random item over a small key pool so hits and evictions happen
    function automatic t_in_item rand_cmd();
        logic [1:0] c;
        logic [63:0] t;
        logic [16:0] l;
        logic [31:0] h;
        logic [15:0] s;
        int k;
        k = $urandom_range(0, 47);
        t = (k < 44) ? {32'hA5A5_0000 ^ $urandom_range(0, 3) << 20, 32'(k)}
                     : {$urandom, $urandom};
        l = (k < 44) ? 17'(k * 3) : 17'($urandom);
        h = $urandom_range(0, 9) == 0 ? 32'(k + 1) : ($urandom_range(0, 30) == 0 ? 0 :
            (32'h1000 + 32'($urandom_range(0, 60))) ^ ($urandom_range(0, 1) << 31));
        s = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12000));
        case ($urandom_range(0, 19))
            0: c = CMD_NONE;
            1, 2, 3, 4, 5, 6, 7, 8: c = CMD_LOOKUP;
            9, 10, 11, 12, 13, 14: c = CMD_FILL;
            default: c = CMD_RELEASE;
        endcase
        if ($urandom_range(0, 40) == 0) l = 17'h10001 + 17'($urandom_range(0, 60000));
        return make_cmd(c, t, l, $urandom_range(0, 2) == 0, h, s);
    endfunction

    initial begin
        clear_cache();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, each command, each rejection path
        pending_cmds.push_back(make_cmd(CMD_LOOKUP, '1, 17'd65536, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 17'd65537, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 0, 17'h1FFFF, 1, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 1, 0, 0, 0, 5));
        pending_cmds.push_back(make_cmd(CMD_FILL, 1, 0, 0, 32'h11, 16'h8000));
        pending_cmds.push_back(make_cmd(CMD_FILL, 1, 0, 0, 32'h12, 16'd10001));
        pending_cmds.push_back(make_cmd(CMD_FILL, 1, 0, 0, 32'h13, 16'd10000));
        pending_cmds.push_back(make_cmd(CMD_FILL, '1, 17'd65536, 1, 32'hFFFF_FFFF, 16'h7FFF));
        pending_cmds.push_back(make_cmd(CMD_FILL, '1, 17'd65536, 1, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(CMD_FILL, 1, 0, 0, 32'h14, 0));
        pending_cmds.push_back(make_cmd(CMD_LOOKUP, '1, 17'd65536, 1, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_LOOKUP, 1, 0, 1, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_NONE, '1, '1, 1, '1, '1));
        pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 32'h7777, 0));
        drain();

        // limit extremes with boundary counts
        write_limit(15'd0);
        pending_cmds.push_back(make_cmd(CMD_FILL, 5, 5, 0, 32'h21, 16'd1));
        pending_cmds.push_back(make_cmd(CMD_FILL, 5, 5, 0, 32'h22, 16'd0));
        drain();
        write_limit(15'h7FFF);
        pending_cmds.push_back(make_cmd(CMD_FILL, 6, 6, 0, 32'h23, 16'h7FFF));
        drain();
        write_limit(MAX_STATES_RESET);

        // fill all slots pinned, then uncached fill, then unpin
        for (int i = 0; i < SLOT_COUNT; i++)
            pending_cmds.push_back(make_cmd(CMD_FILL, 64'(100 + i), 3, 1, 32'(500 + i), 1));
        pending_cmds.push_back(make_cmd(CMD_FILL, 99, 3, 0, 32'h999, 1));
        for (int i = 0; i < SLOT_COUNT; i++)
            pending_cmds.push_back(make_cmd(CMD_RELEASE, 0, 0, 0, 32'(500 + i), 0));
        // sender pause until all results are back
        drain();

        // receiver long hold while the sender keeps offering
        long_hold_req <= 1'b1;
        for (int i = 0; i < 20; i++) pending_cmds.push_back(rand_cmd());
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 400; i++) pending_cmds.push_back(rand_cmd());
            drain();
            write_limit(ph == 0 ? 15'd0 : (ph == 1 ? 15'h7FFF : 15'($urandom)));
        end
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
